>>> sv/flia_pkg.sv
package flia_pkg;

  // Default number of IDs handed out by the allocator.
  localparam int unsigned FLIA_CAPACITY = 1024;

  // Request codes as they appear on the input channel.
  localparam logic [1:0] REQ_ALLOCATE = 2'd0;
  localparam logic [1:0] REQ_RELEASE  = 2'd1;
  localparam logic [1:0] REQ_QUERY    = 2'd2;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_LIVE = 2'd1;
  localparam logic [1:0] ST_NO_FREE  = 2'd2;

  // Operation after classification by the front end.
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_QUERY,
    OP_NOP
  } op_e;

  // One classified request waiting for the back end.
  typedef struct packed {
    op_e         op;
    logic [15:0] slot_id;
    logic        in_range;
  } work_t;

  // Bookkeeping counters exported by the back end, zero-extended.
  typedef struct packed {
    logic [16:0] freed_count;
    logic [16:0] next_fresh;
  } alloc_stats_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } back_state_e;

endpackage

>>> sv/flia_front.sv
module flia_front #(
  parameter int unsigned CAPACITY = flia_pkg::FLIA_CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [15:0]           slot_id_i,
  output logic                  q_valid_o,
  output flia_pkg::work_t       q_item_o,
  input  logic                  q_pop_i
);
  import flia_pkg::*;

  localparam logic [16:0] CapLimit = 17'(CAPACITY);

  work_t      cls_item;
  work_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  // Classify the request: decode its kind and check the ID range.
  always_comb begin
    cls_item.slot_id  = slot_id_i;
    cls_item.in_range = ({1'b0, slot_id_i} < CapLimit);
    unique case (req_type_i)
      REQ_ALLOCATE: cls_item.op = OP_ALLOC;
      REQ_RELEASE:  cls_item.op = OP_RELEASE;
      REQ_QUERY:    cls_item.op = OP_QUERY;
      default:      cls_item.op = OP_NOP;
    endcase
  end

  // Two-entry queue toward the back end.
  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (fill_q != 2'd0);
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

>>> sv/flia_back.sv
module flia_back #(
  parameter int unsigned CAPACITY = flia_pkg::FLIA_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  flia_pkg::work_t        q_item_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [15:0]            result_id_o,
  output logic [1:0]             status_o,
  output logic                   is_live_o,
  output flia_pkg::alloc_stats_t stats_o
);
  import flia_pkg::*;

  localparam int unsigned IDW = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  back_state_e     state_q, state_d;
  work_t           item_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   fresh_q, fresh_d;
  logic            out_valid_q;
  logic [15:0]     res_id_q, res_id;
  logic [1:0]      status_q, status;
  logic            live_q, live;
  logic            out_free, issue, eval_fire;
  logic            live_now;
  logic [IDW-1:0]  item_id;

  logic [IDW-1:0]  stack_mem [CAPACITY];
  logic [IDW-1:0]  stack_rd_q;
  logic            stack_we;
  logic [IDW-1:0]  stack_waddr;
  logic [IDW-1:0]  stack_raddr;

  logic            flag_mem [CAPACITY];
  logic            flag_rd_q;
  logic            flag_we;
  logic            flag_wdata;
  logic [IDW-1:0]  flag_waddr;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign item_id   = item_q.slot_id[IDW-1:0];

  // Next state: fetch one item, then resolve it once the output is free.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_EVAL;
      BK_EVAL: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop_o   = 1'b0;
    eval_fire = 1'b0;
    unique case (state_q)
      BK_IDLE: q_pop_o = q_valid_i;
      BK_EVAL: eval_fire = out_free;
      default: ;
    endcase
  end

  assign issue = q_pop_o;

  // The stack top sits one below the fill count.
  assign stack_raddr = IDW'(count_q - CW'(1));

  // Memory reads are issued together with the pop and held until the next one.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      stack_rd_q <= stack_mem[stack_raddr];
      flag_rd_q  <= flag_mem[q_item_i.slot_id[IDW-1:0]];
    end
  end

  // Memory writes happen in the resolve cycle only.
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= item_id;
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // An ID at or above the fresh mark was never handed out, so its flag is
  // treated as clear without ever being written.
  assign live_now = item_q.in_range && (CW'(item_id) < fresh_q) && flag_rd_q;

  // Resolve the request against the stack and the live flags.
  always_comb begin
    res_id      = item_q.slot_id;
    status      = ST_OK;
    live        = 1'b0;
    count_d     = count_q;
    fresh_d     = fresh_q;
    stack_we    = 1'b0;
    stack_waddr = count_q[IDW-1:0];
    flag_we     = 1'b0;
    flag_wdata  = 1'b0;
    flag_waddr  = item_id;
    case (item_q.op)
      OP_ALLOC: begin
        if (count_q != '0) begin
          count_d    = count_q - CW'(1);
          res_id     = 16'(stack_rd_q);
          flag_we    = eval_fire;
          flag_wdata = 1'b1;
          flag_waddr = stack_rd_q;
        end else if (fresh_q != CapCount) begin
          fresh_d    = fresh_q + CW'(1);
          res_id     = 16'(fresh_q[IDW-1:0]);
          flag_we    = eval_fire;
          flag_wdata = 1'b1;
          flag_waddr = fresh_q[IDW-1:0];
        end else begin
          res_id = 16'd0;
          status = ST_NO_FREE;
        end
      end
      OP_RELEASE: begin
        if (live_now && (count_q != CapCount)) begin
          count_d    = count_q + CW'(1);
          stack_we   = eval_fire;
          flag_we    = eval_fire;
          flag_wdata = 1'b0;
        end else begin
          status = ST_NOT_LIVE;
        end
      end
      OP_QUERY: live = live_now;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (eval_fire) begin
        count_q     <= count_d;
        fresh_q     <= fresh_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Held item and result payload.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      item_q <= q_item_i;
    end
    if (eval_fire) begin
      res_id_q <= res_id;
      status_q <= status;
      live_q   <= live;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = res_id_q;
  assign status_o    = status_q;
  assign is_live_o   = live_q;

  assign stats_o.freed_count = 17'(count_q);
  assign stats_o.next_fresh  = 17'(fresh_q);

endmodule

>>> sv/free_list_id_allocator_top.sv
// Free-list ID allocator. Each transaction allocates, releases or queries an
// ID in 0 .. CAPACITY-1 and returns exactly one result, in order. Allocation
// reuses the most recently released ID first and otherwise takes the next
// never-used ID; when every ID is live it returns status 2. A front end
// classifies requests into a two-entry queue, so up to two transactions are
// taken while the back end is busy or the output is stalled. The back end
// does a registered read of the freed stack and live-flag memories, then
// resolves and writes back once the output is free; it takes no new
// transaction before the last is resolved. The live flags need no clearing
// pass after reset: IDs at or above the fresh-ID mark read as not live.
module free_list_id_allocator_top #(
  parameter int unsigned CAPACITY = flia_pkg::FLIA_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] slot_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_id_o,
  output logic [1:0]  status_o,
  output logic        is_live_o
);
  import flia_pkg::*;

  logic         q_valid;
  logic         q_pop;
  work_t        q_item;
  alloc_stats_t stats;

  flia_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .slot_id_i  (slot_id_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  flia_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_id_o (result_id_o),
    .status_o    (status_o),
    .is_live_o   (is_live_o),
    .stats_o     (stats)
  );

  // Every ID on the freed stack was handed out before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stats.freed_count <= stats.next_fresh)
    else $error("freed stack holds more IDs than were ever allocated");

  // The fresh-ID mark never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stats.next_fresh <= 17'(CAPACITY))
    else $error("fresh-ID mark beyond capacity");

  // A query answer only comes with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_live_o |-> status_o == ST_OK)
    else $error("live answer with an error status");

  // Exhaustion only reported when no ID is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NO_FREE |-> result_id_o == 16'd0 &&
      stats.freed_count == 17'd0 && stats.next_fresh == 17'(CAPACITY))
    else $error("exhaustion reported while IDs remain");

endmodule

>>> sim/testbench.sv
module testbench;
  import flia_pkg::*;

  localparam int unsigned CAPACITY = FLIA_CAPACITY;
  localparam int unsigned IDLE_PCT = 28;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_REQS = 300;
  localparam int unsigned FILL_REQS = 400;
  localparam int unsigned SETTLE_CYCLES = 20;

  // The fourth request code has no meaning and is passed through untouched.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // One request waiting to be driven; drain_first holds it back until every
  // earlier transaction has returned its result.
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] slot_id;
    bit          drain_first;
  } request_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic [1:0]  status;
    logic        is_live;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_QUERY;
  logic [15:0] slot_id_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_id_o;
  logic [1:0]  status_o;
  logic        is_live_o;

  request_t    req_queue[$];
  reply_t      reply_queue[$];

  // Shadow copy of the allocator state.
  bit          live_map[CAPACITY];
  logic [15:0] freed_ids[$];
  int unsigned fresh_mark = 0;

  int unsigned accepted_reqs = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  logic        in_taken = 1'b0;
  logic        calm;

  // Neither side idles while this window of transactions goes through.
  assign calm = (accepted_reqs >= 400) && (accepted_reqs < 600);

  free_list_id_allocator_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .slot_id_i  (slot_id_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_id_o(result_id_o),
    .status_o   (status_o),
    .is_live_o  (is_live_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one request to the shadow state and returns the reply it earns.
  function automatic reply_t compute_reply(logic [1:0] kind, logic [15:0] sid);
    reply_t      r;
    bit          in_range;
    r.result_id = sid;
    r.status = ST_OK;
    r.is_live = 1'b0;
    in_range = (sid < CAPACITY);
    case (kind)
      REQ_ALLOCATE: begin
        if (freed_ids.size() != 0) begin
          r.result_id = freed_ids.pop_back();
          live_map[r.result_id] = 1'b1;
        end else if (fresh_mark < CAPACITY) begin
          r.result_id = 16'(fresh_mark);
          live_map[fresh_mark] = 1'b1;
          fresh_mark++;
        end else begin
          r.result_id = 16'd0;
          r.status = ST_NO_FREE;
        end
      end
      REQ_RELEASE: begin
        if (in_range && live_map[sid]) begin
          live_map[sid] = 1'b0;
          freed_ids.insert(freed_ids.size(), sid);
        end else begin
          r.status = ST_NOT_LIVE;
        end
      end
      REQ_QUERY: begin
        r.is_live = in_range && live_map[sid];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  task automatic add_request(input logic [1:0] kind, input logic [15:0] sid,
                             input bit drain_first);
    request_t rq;
    rq.kind = kind;
    rq.slot_id = sid;
    rq.drain_first = drain_first;
    req_queue.insert(req_queue.size(), rq);
  endtask

  // Picks an ID below the number of allocations issued so far, where most
  // live IDs sit.
  function automatic logic [15:0] recent_id(int unsigned issued);
    int unsigned span;
    span = (issued > CAPACITY) ? CAPACITY : issued;
    if (span == 0) begin
      return 16'd0;
    end
    return 16'($urandom_range(span - 1, 0));
  endfunction

  // Stimulus: directed corner cases, a random mix, a long allocation run, then a release and allocate mix.
  initial begin : stimulus
    int unsigned issued_allocs;
    int unsigned alloc_pct;
    int unsigned roll;
    issued_allocs = 0;

    // Empty allocator, dead and out-of-range IDs, LIFO reuse, unused code.
    add_request(REQ_QUERY, 16'd0, 1'b0);
    add_request(REQ_RELEASE, 16'd0, 1'b0);
    add_request(REQ_ALLOCATE, 16'd0, 1'b0);
    add_request(REQ_ALLOCATE, 16'hFFFF, 1'b0);
    add_request(REQ_ALLOCATE, 16'd7, 1'b0);
    add_request(REQ_QUERY, 16'd1, 1'b0);
    add_request(REQ_QUERY, 16'(CAPACITY), 1'b0);
    add_request(REQ_QUERY, 16'hFFFF, 1'b0);
    add_request(REQ_RELEASE, 16'hFFFF, 1'b0);
    add_request(REQ_RELEASE, 16'(CAPACITY), 1'b0);
    add_request(REQ_RELEASE, 16'd1, 1'b0);
    add_request(REQ_RELEASE, 16'd1, 1'b0);
    add_request(REQ_RELEASE, 16'd2, 1'b0);
    add_request(REQ_QUERY, 16'd2, 1'b0);
    add_request(REQ_ALLOCATE, 16'd0, 1'b0);
    add_request(REQ_ALLOCATE, 16'd0, 1'b0);
    add_request(REQ_ALLOCATE, 16'd0, 1'b0);
    add_request(REQ_UNUSED, 16'hFFFF, 1'b0);
    add_request(REQ_UNUSED, 16'd0, 1'b0);
    add_request(REQ_ALLOCATE, 16'hA5A5, 1'b0);
    add_request(REQ_QUERY, 16'(CAPACITY - 1), 1'b0);
    add_request(REQ_RELEASE, 16'(CAPACITY - 1), 1'b0);
    add_request(REQ_QUERY, 16'd4, 1'b0);
    issued_allocs = 6;

    // Random mix with a release-heavy stretch in the middle.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      alloc_pct = (i >= 120 && i < 180) ? 20 : 42;
      roll = $urandom_range(99, 0);
      if (roll < alloc_pct) begin
        add_request(REQ_ALLOCATE, 16'($urandom), 1'b0);
        issued_allocs++;
      end else if (roll < 80) begin
        add_request(REQ_RELEASE, recent_id(issued_allocs), 1'b0);
      end else if (roll < 92) begin
        add_request(REQ_QUERY, recent_id(issued_allocs + 1), 1'b0);
      end else begin
        case ($urandom_range(2, 0))
          0: add_request(REQ_UNUSED, 16'($urandom), 1'b0);
          1: add_request(REQ_RELEASE, 16'($urandom), 1'b0);
          default: add_request(REQ_QUERY, 16'($urandom), 1'b0);
        endcase
      end
    end

    // Long run of allocations; the first one waits for a drain.
    for (int n = 0; n < FILL_REQS; n++) begin
      add_request(REQ_ALLOCATE, 16'($urandom), n == 0);
      if (n % 64 == 63) begin
        add_request(REQ_QUERY, 16'($urandom_range(CAPACITY - 1, 0)), 1'b0);
      end
    end

    // Free a few IDs, then allocate past them so the stack and fresh IDs mix.
    for (int n = 0; n < 20; n++) begin
      add_request(REQ_RELEASE, 16'($urandom_range(CAPACITY - 1, 0)), 1'b0);
    end
    for (int n = 0; n < 25; n++) begin
      add_request(REQ_ALLOCATE, 16'($urandom), 1'b0);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || in_valid_i || reply_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Request driver: presents the next request at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (req_queue.size() != 0 &&
          !(req_queue[0].drain_first && reply_queue.size() != 0) &&
          (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        req_type_i <= req_queue[0].kind;
        slot_id_i <= req_queue[0].slot_id;
        req_queue.delete(0);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  // Monitor: checks each result transaction, then predicts each new request.
  always @(posedge clk_i) begin : monitor
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual id %0d status %0d live %0d",
                   $time, result_id_o, status_o, is_live_o);
          errors++;
        end else begin
          want = reply_queue[0];
          reply_queue.delete(0);
          check_field("result_id", want.result_id, result_id_o);
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("is_live", 16'(want.is_live), 16'(is_live_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        reply_queue.insert(reply_queue.size(), compute_reply(req_type_i, slot_id_i));
        accepted_reqs <= accepted_reqs + 1;
      end
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

>>> sim.f
sv/flia_pkg.sv
sv/flia_front.sv
sv/flia_back.sv
sv/free_list_id_allocator_top.sv
sim/testbench.sv
